FILE: rtl/cpd_pkg.sv
// ============================================================================
// cpd_pkg
// Shared types and constants of the color presence detector.
// ============================================================================
package cpd_pkg;

    // Number of color boxes, in priority order red, green, blue, yellow, black
    localparam int NUM_COLORS = 5;

    // Pixel channel width and packed box width
    localparam int CHAN_W = 8;
    localparam int BOX_W  = 6 * CHAN_W;
    localparam int PCT_W  = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BOX_W;

    // Register indexes: boxes occupy CFG_BOX_FIRST .. CFG_BOX_FIRST+NUM_COLORS-1
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [BOX_W-1:0] BOX_RESET [NUM_COLORS] = '{
        48'd280591062138880,
        48'd56071636948480,
        48'd55194607943830,
        48'd281471530472960,
        48'd66229402337280
    };
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd15;

    // Scale applied to a color count before the threshold compare
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result codes
    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_RED    = 3'd1,
        CLS_GREEN  = 3'd2,
        CLS_BLUE   = 3'd3,
        CLS_YELLOW = 3'd4,
        CLS_BLACK  = 3'd5
    } color_class_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic                  last;
        logic [NUM_COLORS-1:0] hit;
    } cpd_item_t;

endpackage

FILE: rtl/cpd_front.sv
// ============================================================================
// cpd_front
// Holds the color boxes and classifies each accepted pixel against them.
// ============================================================================
module cpd_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // blue, green, red
    input  logic                           s_tlast,   // last_pixel
    // classified item toward the queue
    output logic                           item_valid,
    input  logic                           item_ready,
    output cpd_pkg::cpd_item_t             item
);
    import cpd_pkg::*;

    logic [BOX_W-1:0]  box_reg [NUM_COLORS];
    logic [CHAN_W-1:0] px [3];

    // Box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                box_reg[k] <= BOX_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                if (cfg_index == CFG_BOX_FIRST + CFG_IDX_W'(k))
                begin
                    box_reg[k] <= cfg_data[BOX_W-1:0];
                end
            end
        end
    end

    // Inclusive box test on every channel; an empty box never matches
    always_comb
    begin
        px[0] = s_tdata[CHAN_W-1:0];
        px[1] = s_tdata[2*CHAN_W-1:CHAN_W];
        px[2] = s_tdata[3*CHAN_W-1:2*CHAN_W];
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            item.hit[k] = 1'b1;
            for (int c = 0; c < 3; c++)
            begin
                if (px[c] < box_reg[k][c*CHAN_W +: CHAN_W] ||
                    px[c] > box_reg[k][(3+c)*CHAN_W +: CHAN_W])
                begin
                    item.hit[k] = 1'b0;
                end
            end
        end
        item.last = s_tlast;
    end

    assign item_valid = s_tvalid;
    assign s_tready   = item_ready;

endmodule

FILE: rtl/cpd_queue.sv
// ============================================================================
// cpd_queue
// Short register queue between the classifier and the counting back end.
// ============================================================================
module cpd_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpd_pkg::cpd_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cpd_pkg::cpd_item_t out_item
);
    import cpd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cpd_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/cpd_back.sv
// ============================================================================
// cpd_back
// Per-color saturating counters, threshold test at frame end, result register.
// ============================================================================
module cpd_back
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
    // classified items from the queue
    input  logic                           item_valid,
    output logic                           item_ready,
    input  cpd_pkg::cpd_item_t             item,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata    // color_class, detected
);
    import cpd_pkg::*;

    localparam int PROD_W = COUNT_BITS + PCT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [PCT_W-1:0]      pct_reg;
    logic [COUNT_BITS-1:0] cnt_reg [NUM_COLORS];
    logic [COUNT_BITS-1:0] cnt_next [NUM_COLORS];
    logic [COUNT_BITS-1:0] tot_reg, tot_next;

    // frame snapshot stage
    logic                  s1_valid_reg;
    logic [COUNT_BITS-1:0] s1_cnt_reg [NUM_COLORS];
    logic [COUNT_BITS-1:0] s1_tot_reg;
    // product stage
    logic                  s2_valid_reg;
    logic [PROD_W-1:0]     s2_cnt_reg [NUM_COLORS];
    logic [PROD_W-1:0]     s2_thr_reg;
    // result register
    logic                  m_tvalid_reg;
    color_class_t          cls_reg, cls_next;
    logic                  det_reg, det_next;

    logic o_free, s2_free, s1_free, pop;

    // Stage flow: a stage moves when the one after it has room
    assign o_free     = !m_tvalid_reg || m_tready;
    assign s2_free    = !s2_valid_reg || o_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item_ready = !item.last || s1_free;
    assign pop        = item_valid && item_ready;

    // Presence threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= PCT_RESET;
        end
        else if (cfg_we && cfg_index == CFG_PERCENT)
        begin
            pct_reg <= cfg_data[PCT_W-1:0];
        end
    end

    // Saturating increments for this item
    always_comb
    begin
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (item.hit[k] && cnt_reg[k] != CNT_MAX)
            begin
                cnt_next[k] = cnt_reg[k] + 1'b1;
            end
        end
        tot_next = (tot_reg != CNT_MAX) ? tot_reg + 1'b1 : tot_reg;
    end

    // Running counters; cleared after the last pixel of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            tot_reg <= '0;
        end
        else if (pop)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                cnt_reg[k] <= item.last ? '0 : cnt_next[k];
            end
            tot_reg <= item.last ? '0 : tot_next;
        end
    end

    // Valid flags of the result pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pop && item.last;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (o_free)
            begin
                m_tvalid_reg <= s2_valid_reg;
            end
        end
    end

    // Snapshot at frame end, cross-multiply count * 100 against percent * total, register the result
    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                s1_cnt_reg[k] <= cnt_next[k];
            end
            s1_tot_reg <= tot_next;
        end
        if (s1_valid_reg && s2_free)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                s2_cnt_reg[k] <= PROD_W'(s1_cnt_reg[k]) * PROD_W'(PCT_SCALE);
            end
            s2_thr_reg <= PROD_W'(s1_tot_reg) * PROD_W'(pct_reg);
        end
        if (s2_valid_reg && o_free)
        begin
            cls_reg <= cls_next;
            det_reg <= det_next;
        end
    end

    // First color in priority order that passes the threshold
    always_comb
    begin
        cls_next = CLS_NONE;
        for (int k = NUM_COLORS - 1; k >= 0; k--)
        begin
            if (s2_cnt_reg[k] > s2_thr_reg)
            begin
                cls_next = color_class_t'(3'(k + 1));
            end
        end
        det_next = (cls_next != CLS_NONE) && (cls_next != CLS_BLACK);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, det_reg, cls_reg};

endmodule

FILE: rtl/color_presence_detector.sv
// ============================================================================
// color_presence_detector
// Counts pixels in five color boxes and reports per frame the first color over the threshold.
// ============================================================================
// Throughput: one pixel per cycle, sustained while the result side keeps up.
// Result path: a frame's last accepted pixel passes the queue, the count
//   snapshot, the multiply stage and the compare into the result register.
// Reset: counters and pipeline flags clear; boxes and the percent threshold
//   return to their default values. No clearing pass is needed.
module color_presence_detector
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    input  logic                           s_tlast,   // last_pixel
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata    // [2:0] color_class, [3] detected
);
    import cpd_pkg::*;

    logic      fq_valid, fq_ready;
    cpd_item_t fq_item;
    logic      qb_valid, qb_ready;
    cpd_item_t qb_item;

    // Classifier
    cpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    // Decoupling queue
    cpd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Counters and frame decision
    cpd_back
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: bench/color_presence_detector_tb.sv
// ============================================================================
// color_presence_detector_tb
// Self-checking bench for the color presence detector. Pixel frames go in on
// the slave stream and one verdict per frame is expected on the master
// stream. A predictor in the bench tracks the color boxes, the percent
// threshold and the saturating counters, and each verdict is checked field
// by field. Config changes only while the block is idle. Both streams idle at
// random, the sink holds off once for a long stretch, and short counters
// (COUNT_BITS = 8) make saturation reachable.
// ============================================================================
module color_presence_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpd_pkg::*;

    // Short counters so that long frames saturate them
    localparam int CNT_W = 8;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;

    // Indexes past the last register; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int     SETTLE_CYCLES = 8;
    localparam int     LONG_HOLD     = 400;
    localparam longint CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic       last;
    } pixel_t;

    typedef struct packed {
        color_class_t cls;
        logic         detected;
    } verdict_t;

    // DUT ports; every input is driven to a known value from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;  // [7:0] blue, [15:8] green, [23:16] red
    logic                  s_tlast   = 1'b0; // last_pixel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [2:0] color_class, [3] detected

    // Predictor state
    logic [BOX_W-1:0]  mdl_box [NUM_COLORS];
    logic [PCT_W-1:0]  mdl_pct;
    longint unsigned   mdl_count [NUM_COLORS];
    longint unsigned   mdl_total;

    // Pixels waiting to be sent, verdicts waiting to arrive
    pixel_t   pixel_fifo [$];
    verdict_t frame_verdicts [$];
    pixel_t   cur_pixel;
    verdict_t want;

    int     n_queued     = 0;
    int     n_accepted   = 0;
    int     errors       = 0;
    longint cycles       = 0;
    bit     pixel_taken  = 1'b0;
    bit     src_idle_en  = 1'b1;
    bit     sink_idle_en = 1'b1;
    int     src_gap      = 0;
    int     sink_gap     = 0;
    int     hold_req     = 0;
    int     hold_ack     = 0;
    int     hold_left    = 0;

    color_presence_detector #(
        .COUNT_BITS (CNT_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Inclusive box test on all three channels
    function automatic bit box_hit(input logic [BOX_W-1:0] box, input pixel_t px);
        logic [7:0] ch [3];
        ch[0] = px.b;
        ch[1] = px.g;
        ch[2] = px.r;
        for (int c = 0; c < 3; c++)
        begin
            if (ch[c] < box[8*c +: 8] || ch[c] > box[24 + 8*c +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Count one pixel; on the frame's last pixel queue the verdict and clear
    function automatic void classify_pixel(input pixel_t px);
        verdict_t v;
        int       k;
        for (k = 0; k < NUM_COLORS; k++)
        begin
            if (box_hit(mdl_box[k], px) && mdl_count[k] < CNT_MAX)
                mdl_count[k]++;
        end
        if (mdl_total < CNT_MAX)
            mdl_total++;
        if (!px.last)
            return;

        // first color in priority order above the threshold wins
        v.cls = CLS_NONE;
        for (k = 0; k < NUM_COLORS; k++)
        begin
            if (mdl_count[k] * PCT_SCALE > longint'(mdl_pct) * mdl_total)
            begin
                v.cls = color_class_t'(k + 1);
                break;
            end
        end
        v.detected = (v.cls != CLS_NONE && v.cls != CLS_BLACK);
        frame_verdicts.insert(frame_verdicts.size(), v);

        for (k = 0; k < NUM_COLORS; k++)
            mdl_count[k] = 0;
        mdl_total = 0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic pixel_t mk_pixel(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, input bit last);
        pixel_t px;
        px.b    = b;
        px.g    = g;
        px.r    = r;
        px.last = last;
        return px;
    endfunction

    function automatic pixel_t any_pixel(input bit last);
        return mk_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), last);
    endfunction

    function automatic bit box_open(input int k);
        logic [BOX_W-1:0] bx;
        bx = mdl_box[k];
        return bx[7:0] <= bx[31:24] && bx[15:8] <= bx[39:32] && bx[23:16] <= bx[47:40];
    endfunction

    // Random pixel inside box k; the box must not be empty
    function automatic pixel_t pixel_in(input int k, input bit last);
        logic [BOX_W-1:0] bx;
        bx = mdl_box[k];
        return mk_pixel(8'($urandom_range(bx[31:24], bx[7:0])),
                        8'($urandom_range(bx[39:32], bx[15:8])),
                        8'($urandom_range(bx[47:40], bx[23:16])), last);
    endfunction

    // Random pixel that no box takes, best effort
    function automatic pixel_t pixel_outside(input bit last);
        pixel_t px;
        bit     hit;
        for (int tries = 0; tries < 50; tries++)
        begin
            px  = any_pixel(last);
            hit = 1'b0;
            for (int k = 0; k < NUM_COLORS; k++)
                hit |= box_hit(mdl_box[k], px);
            if (!hit)
                return px;
        end
        return px;
    endfunction

    function automatic logic [BOX_W-1:0] make_box(
        input logic [7:0] lo_b, input logic [7:0] lo_g, input logic [7:0] lo_r,
        input logic [7:0] hi_b, input logic [7:0] hi_g, input logic [7:0] hi_r);
        return {hi_r, hi_g, hi_b, lo_r, lo_g, lo_b};
    endfunction

    // Random box: mostly ordered ranges, some full, single-value or empty channels
    function automatic logic [BOX_W-1:0] rand_box();
        logic [7:0] lo [3];
        logic [7:0] hi [3];
        logic [7:0] x;
        logic [7:0] y;
        int         mode;
        for (int c = 0; c < 3; c++)
        begin
            mode = $urandom_range(0, 9);
            x    = 8'($urandom_range(0, 255));
            y    = 8'($urandom_range(0, 255));
            case (mode)
                0:
                begin
                    lo[c] = 8'd0;
                    hi[c] = 8'd255;
                end
                1:
                begin
                    lo[c] = 8'($urandom_range(1, 255));
                    hi[c] = 8'($urandom_range(0, lo[c] - 1));
                end
                2:
                begin
                    lo[c] = x;
                    hi[c] = x;
                end
                default:
                begin
                    lo[c] = (x < y) ? x : y;
                    hi[c] = (x < y) ? y : x;
                end
            endcase
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Percent value with junk above the register width
    function automatic logic [CFG_DATA_W-1:0] pct_word(input logic [PCT_W-1:0] pct);
        return {41'($urandom()), pct};
    endfunction

    task automatic push_pixel(input pixel_t px);
        pixel_fifo.insert(pixel_fifo.size(), px);
        n_queued++;
    endtask

    // Config write on the next cycle, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (int'(idx) < int'(CFG_BOX_FIRST) + NUM_COLORS)
            mdl_box[idx - CFG_BOX_FIRST] = val[BOX_W-1:0];
        else if (idx == CFG_PERCENT)
            mdl_pct = val[PCT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every pixel is taken and every verdict is in, then settle
    task automatic wait_drained();
        while (n_accepted != n_queued || frame_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random frames, each aimed at one box or at none
    task automatic gen_frames(input int n_items, input int max_len);
        int done;
        int len;
        int target;
        int sel;
        bit last;
        done = 0;
        while (done < n_items)
        begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, max_len)
                                              : $urandom_range(1, 3 * max_len);
            target = $urandom_range(0, NUM_COLORS);
            for (int i = 0; i < len; i++)
            begin
                sel  = $urandom_range(0, 99);
                last = (i == len - 1);
                if (target < NUM_COLORS && sel < 60 && box_open(target))
                    push_pixel(pixel_in(target, last));
                else if (sel < 85)
                    push_pixel(any_pixel(last));
                else
                    push_pixel(pixel_outside(last));
            end
            done += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Source side: take at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_taken = rst_n && s_tvalid && s_tready;
        if (pixel_taken)
        begin
            classify_pixel(cur_pixel);
            n_accepted++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || pixel_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pixel_fifo.size() > 0)
            begin
                cur_pixel = pixel_fifo.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_pixel.r, cur_pixel.g, cur_pixel.b};
                s_tlast  <= cur_pixel.last;
                src_gap  = (src_idle_en && $urandom_range(0, 99) < 20) ? gap_len() : 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 99) < 20)
        begin
            sink_gap = gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Verdict check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict: expected none, actual class %0d detected %0b",
                         $time, m_tdata[2:0], m_tdata[3]);
                errors++;
            end
            else
            begin
                want = frame_verdicts.pop_front();
                if (m_tdata[2:0] != want.cls)
                begin
                    $display("%0t: color_class mismatch: expected %0d, actual %0d",
                             $time, want.cls, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[3] != want.detected)
                begin
                    $display("%0t: detected mismatch: expected %0b, actual %0b",
                             $time, want.detected, m_tdata[3]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d of %0d pixels taken, %0d verdicts pending",
                     $time, n_accepted, n_queued, frame_verdicts.size());
            $display("color_presence_detector_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [PCT_W-1:0] pct;
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            mdl_box[k]   = BOX_RESET[k];
            mdl_count[k] = 0;
        end
        mdl_pct   = PCT_RESET;
        mdl_total = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, default boxes: channel extremes, one frame per color, no color
        push_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        push_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        push_pixel(mk_pixel(8'd255, 8'd0, 8'd0, 1'b1));
        push_pixel(mk_pixel(8'd0, 8'd255, 8'd0, 1'b1));
        push_pixel(mk_pixel(8'd0, 8'd0, 8'd255, 1'b1));
        for (int k = 0; k < NUM_COLORS; k++)
        begin
            if (box_open(k))
                push_pixel(pixel_in(k, 1'b1));
        end
        push_pixel(pixel_outside(1'b1));
        wait_drained();

        // Threshold edge at 50 percent: exactly half is not enough
        write_reg(CFG_PERCENT, BOX_W'(7'd50));
        push_pixel(pixel_in(0, 1'b0));
        push_pixel(pixel_outside(1'b1));
        push_pixel(pixel_in(0, 1'b0));
        push_pixel(pixel_in(0, 1'b0));
        push_pixel(pixel_outside(1'b1));
        wait_drained();

        // Random settings, percent extremes first
        for (int p = 0; p < 6; p++)
        begin
            for (int k = 0; k < NUM_COLORS; k++)
                write_reg(CFG_BOX_FIRST + 3'(k), rand_box());
            if (p == 0)
                write_reg(CFG_BOX_FIRST, '0);
            if (p == 3)
                write_reg(CFG_BOX_FIRST + 3'd1, make_box(8'd0, 8'd0, 8'd0,
                                                         8'd255, 8'd255, 8'd255));
            case (p)
                0:       pct = 7'd0;
                1:       pct = 7'd100;
                2:       pct = 7'd127;
                default: pct = 7'($urandom_range(5, 60));
            endcase
            write_reg(CFG_PERCENT, pct_word(pct));
            write_reg((p % 2) ? CFG_SPARE_HI : CFG_SPARE_LO, 48'({$urandom(), $urandom()}));
            src_idle_en  = (p != 4) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (p != 4) && ($urandom_range(0, 3) != 0);
            gen_frames(20, 8);
            wait_drained();
        end

        // Long sink hold-off with a steady source of short frames
        write_reg(CFG_PERCENT, pct_word(PCT_W'($urandom_range(5, 40))));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req++;
        gen_frames(40, 1);
        wait_drained();

        // Saturation: red takes r 0..127, green r 128..200, the rest empty
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        write_reg(CFG_BOX_FIRST, make_box(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd127));
        write_reg(CFG_BOX_FIRST + 3'd1, make_box(8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd200));
        for (int k = 2; k < NUM_COLORS; k++)
            write_reg(CFG_BOX_FIRST + 3'(k), make_box(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0));

        // color count and total both pinned at full scale
        write_reg(CFG_PERCENT, BOX_W'(7'd99));
        for (int i = 0; i < 257; i++)
            push_pixel(pixel_in(0, 1'b0));
        push_pixel(pixel_in(1, 1'b1));
        wait_drained();

        // total pinned while the color count stays small
        write_reg(CFG_PERCENT, BOX_W'(7'd20));
        for (int i = 0; i < 206; i++)
            push_pixel(mk_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(201, 255)), 1'b0));
        for (int i = 0; i < 50; i++)
            push_pixel(pixel_in(0, i == 49));
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("color_presence_detector_tb passed");
        else
            $display("color_presence_detector_tb failed");
        $finish;
    end

endmodule
